[rtl/core/x86rid_pkg.sv]
package x86rid_pkg;

  localparam int unsigned REG_W   = 16;
  localparam int unsigned REG_NUM = 8;
  localparam int unsigned IDX_W   = $clog2(REG_NUM);

  typedef logic [REG_W-1:0] word_t;
  typedef logic [IDX_W-1:0] ridx_t;

  // Register indexes
  localparam ridx_t IDX_AX = 3'd0;
  localparam ridx_t IDX_BX = 3'd3;
  localparam ridx_t IDX_BP = 3'd5;
  localparam ridx_t IDX_SI = 3'd6;
  localparam ridx_t IDX_DI = 3'd7;

  // Opcode groups (upper five bits) and single opcodes
  localparam logic [4:0] OPG_INC  = 5'b01000;
  localparam logic [4:0] OPG_DEC  = 5'b01001;
  localparam logic [4:0] OPG_XCHG = 5'b10010;
  localparam logic [7:0] OP_NOP   = 8'h90;
  localparam logic [7:0] OP_LEA   = 8'h8D;

  // ModR/M mod field
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  // rm forms
  localparam logic [2:0] RM_BX_SI = 3'd0;
  localparam logic [2:0] RM_BX_DI = 3'd1;
  localparam logic [2:0] RM_BP_SI = 3'd2;
  localparam logic [2:0] RM_BP_DI = 3'd3;
  localparam logic [2:0] RM_SI    = 3'd4;
  localparam logic [2:0] RM_DI    = 3'd5;
  localparam logic [2:0] RM_BP    = 3'd6;
  localparam logic [2:0] RM_BX    = 3'd7;

  localparam word_t INC_OVF_VAL = 16'h7FFF;
  localparam word_t DEC_OVF_VAL = 16'h8000;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic pf;
    logic af;
  } flags_t;

endpackage

[rtl/core/x86_register_inc_dec_xchg_lea_unit.sv]
// Execute unit for INC/DEC reg16, XCHG AX,reg16, NOP and LEA reg16,mem of a
// 16-bit x86 core, holding its own eight-word register file and OF/SF/ZF/PF/AF.
//
// Input channel (in_valid / in_stall): opcode byte, ModR/M byte and a 16-bit
// displacement per instruction. Output channel (out_valid / out_stall): fault,
// written register index and value, AX and the five flags after execution.
//
// The instruction is captured in an input register, then executes against the
// register file and its result is captured in the output register. Throughput
// is one instruction per cycle while the output is not stalled; the register
// file and flags update in that same execute step, so the next instruction
// sees them without bubbles.
//
// While the receiver stalls with a result pending, the instruction in the
// input register waits, and in_stall rises only once that register is full.
// Reset clears all eight registers, the flags and both valid bits.
module x86_register_inc_dec_xchg_lea_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opcode_byte,
  input  logic [7:0]  in_modrm_byte,
  input  logic [15:0] in_displacement,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fault,
  output logic [2:0]  out_dest_index,
  output logic [15:0] out_dest_value,
  output logic [15:0] out_ax_value,
  output logic        out_overflow_flag,
  output logic        out_sign_flag,
  output logic        out_zero_flag,
  output logic        out_parity_flag,
  output logic        out_aux_flag
);
  import x86rid_pkg::*;

  // Input register
  logic       in_valid_r;
  logic [7:0] op_r;
  logic [7:0] modrm_r;
  word_t      disp_r;

  // Architectural state
  word_t  regs_r [REG_NUM];
  flags_t flags_r;

  // Output register
  logic   out_valid_r;
  logic   fault_r;
  ridx_t  dest_idx_r;
  word_t  dest_val_r;
  word_t  ax_val_r;
  flags_t oflags_r;

  logic   advance;
  logic   in_load;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_load  = in_valid && !in_stall;

  // Decode
  logic       is_inc, is_dec, is_xchg, is_lea;
  logic [1:0] mod_f;
  logic [2:0] rm_f;
  ridx_t      op_idx;
  ridx_t      lea_idx;
  word_t      op_reg;
  word_t      ax_cur;

  always_comb begin
    op_idx  = op_r[2:0];
    mod_f   = modrm_r[7:6];
    rm_f    = modrm_r[2:0];
    lea_idx = modrm_r[5:3];
    is_inc  = (op_r[7:3] == OPG_INC);
    is_dec  = (op_r[7:3] == OPG_DEC);
    is_xchg = (op_r[7:3] == OPG_XCHG) && (op_r != OP_NOP);
    is_lea  = (op_r == OP_LEA) && (mod_f != MOD_REG);
    op_reg  = regs_r[op_idx];
    ax_cur  = regs_r[IDX_AX];
  end

  // Effective address
  word_t base, offs, ea;

  always_comb begin
    case (rm_f)
      RM_BX_SI: base = regs_r[IDX_BX] + regs_r[IDX_SI];
      RM_BX_DI: base = regs_r[IDX_BX] + regs_r[IDX_DI];
      RM_BP_SI: base = regs_r[IDX_BP] + regs_r[IDX_SI];
      RM_BP_DI: base = regs_r[IDX_BP] + regs_r[IDX_DI];
      RM_SI:    base = regs_r[IDX_SI];
      RM_DI:    base = regs_r[IDX_DI];
      RM_BP:    base = regs_r[IDX_BP];
      default:  base = regs_r[IDX_BX];
    endcase
    case (mod_f)
      MOD_NODISP: offs = '0;
      MOD_DISP8:  offs = {{8{disp_r[7]}}, disp_r[7:0]};
      default:    offs = disp_r;
    endcase
    // Direct address form
    if (mod_f == MOD_NODISP && rm_f == RM_BP) begin
      ea = disp_r;
    end else begin
      ea = base + offs;
    end
  end

  // Execute
  word_t  incdec_val;
  logic   wr_en;
  ridx_t  wr_idx;
  word_t  wr_val;
  word_t  ax_nxt;
  flags_t flags_nxt;
  logic   fault_nxt;

  always_comb begin
    incdec_val = is_inc ? op_reg + 16'd1 : op_reg - 16'd1;
    flags_nxt  = flags_r;
    wr_en      = 1'b0;
    wr_idx     = IDX_AX;
    wr_val     = ax_cur;
    fault_nxt  = 1'b0;
    if (is_inc || is_dec) begin
      wr_en        = 1'b1;
      wr_idx       = op_idx;
      wr_val       = incdec_val;
      flags_nxt.of = is_inc ? (op_reg == INC_OVF_VAL) : (op_reg == DEC_OVF_VAL);
      flags_nxt.sf = incdec_val[REG_W-1];
      flags_nxt.zf = (incdec_val == '0);
      flags_nxt.pf = ~^incdec_val[7:0];
      flags_nxt.af = op_reg[4] ^ incdec_val[4];
    end else if (is_xchg) begin
      wr_en  = 1'b1;
      wr_idx = op_idx;
      wr_val = ax_cur;
    end else if (is_lea) begin
      wr_en  = 1'b1;
      wr_idx = lea_idx;
      wr_val = ea;
    end else if (op_r != OP_NOP) begin
      fault_nxt = 1'b1;
    end
    if (is_xchg) begin
      ax_nxt = op_reg;
    end else if (wr_en && wr_idx == IDX_AX) begin
      ax_nxt = wr_val;
    end else begin
      ax_nxt = ax_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      for (int i = 0; i < REG_NUM; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (in_load) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
        if (wr_en) begin
          regs_r[wr_idx] <= wr_val;
        end
        if (is_xchg) begin
          regs_r[IDX_AX] <= op_reg;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_load) begin
      op_r    <= in_opcode_byte;
      modrm_r <= in_modrm_byte;
      disp_r  <= in_displacement;
    end
    if (advance) begin
      fault_r    <= fault_nxt;
      dest_idx_r <= wr_idx;
      dest_val_r <= wr_val;
      ax_val_r   <= ax_nxt;
      oflags_r   <= flags_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = fault_r;
  assign out_dest_index    = dest_idx_r;
  assign out_dest_value    = dest_val_r;
  assign out_ax_value      = ax_val_r;
  assign out_overflow_flag = oflags_r.of;
  assign out_sign_flag     = oflags_r.sf;
  assign out_zero_flag     = oflags_r.zf;
  assign out_parity_flag   = oflags_r.pf;
  assign out_aux_flag      = oflags_r.af;

  a_fault_no_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fault_r |-> dest_idx_r == IDX_AX)
    else $error("faulting transaction names a destination register");

  a_ax_dest_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dest_idx_r == IDX_AX |-> dest_val_r == ax_val_r)
    else $error("AX destination value differs from reported AX");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked pending result");

  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("executed transaction lost before output");

endmodule
